>>> design/ocx_pkg.sv
// Shared types and constants for the order crossover core.
package ocx_pkg;

	localparam int CITY_W = 3;
	localparam logic [1:0] Q_FULL = 2'd2;

	typedef struct packed {
		logic              func;
		logic [CITY_W-1:0] gene_first;
		logic [CITY_W-1:0] gene_second;
		logic [CITY_W-1:0] lo;
		logic [CITY_W-1:0] hi;
		logic              swap_ok;
		logic [CITY_W-1:0] swap_pos;
	} cmd_t;

	typedef struct packed {
		logic [CITY_W-1:0] child_gene;
		logic              last;
	} res_t;

	typedef enum logic [2:0] {
		B_IDLE,
		B_COPY_RD,
		B_COPY_WR,
		B_FILL,
		B_SCAN,
		B_FALL,
		B_EMIT_RD,
		B_EMIT_WR
	} bk_state_t;

endpackage

>>> design/ocx_front.sv
// Front end: input beat acceptance, cut normalization and the command queue.
module ocx_front import ocx_pkg::*; #(
	parameter int CITIES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              func,
	input  logic [CITY_W-1:0] gene_first,
	input  logic [CITY_W-1:0] gene_second,
	input  logic [CITY_W-1:0] cut_lo,
	input  logic [CITY_W-1:0] cut_hi,
	input  logic              swap_enable,
	input  logic [CITY_W-1:0] swap_pos,
	output logic              cmd_valid,
	output cmd_t              cmd,
	input  logic              cmd_pop
);

	localparam int PW = $clog2(CITIES + 1);
	localparam int VW = (PW > CITY_W) ? PW : CITY_W;

	cmd_t              cls;
	logic [CITY_W-1:0] a;
	logic [CITY_W-1:0] b;
	cmd_t              ent_q [2];
	logic              wr_q;
	logic              rd_q;
	logic [1:0]        cnt_q;
	logic              accept;

	always_comb begin
		a = (cut_lo > cut_hi) ? cut_hi : cut_lo;
		b = (cut_lo > cut_hi) ? cut_lo : cut_hi;
		cls.func        = func;
		cls.gene_first  = gene_first;
		cls.gene_second = gene_second;
		cls.lo = (VW'(a) > VW'(CITIES - 1)) ? CITY_W'(CITIES - 1) : a;
		cls.hi = (VW'(b) > VW'(CITIES - 1)) ? CITY_W'(CITIES - 1) : b;
		cls.swap_ok  = swap_enable && (VW'(swap_pos) < VW'(CITIES));
		cls.swap_pos = swap_pos;
	end

	assign full      = (cnt_q == Q_FULL);
	assign accept    = push && !full;
	assign cmd_valid = (cnt_q != 2'd0);
	assign cmd       = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (accept) begin
			ent_q[wr_q] <= cls;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (accept) begin
				wr_q <= ~wr_q;
			end
			if (cmd_pop) begin
				rd_q <= ~rd_q;
			end
			if (accept && !cmd_pop) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!accept && cmd_pop) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		cmd_pop |-> cnt_q != 2'd0)
		else $error("command popped from empty queue");

endmodule

>>> design/ocx_back.sv
// Back end: parent and child memories and the crossover sequencer.
module ocx_back import ocx_pkg::*; #(
	parameter int CITIES = 8
) (
	input  logic clk,
	input  logic arst_n,
	input  logic cmd_valid,
	input  cmd_t cmd,
	output logic cmd_pop,
	output logic res_push,
	output res_t res_data,
	input  logic res_room
);

	localparam int AW = $clog2(CITIES);
	localparam int PW = $clog2(CITIES + 1);
	localparam int VW = (PW > CITY_W) ? PW : CITY_W;
	localparam int MW = 1 << VW;

	bk_state_t state_q;
	bk_state_t state_d;

	logic [CITY_W-1:0] fp_mem_q [CITIES];
	logic [CITY_W-1:0] sp_mem_q [CITIES];
	logic [VW-1:0]     ch_mem_q [CITIES + 1];
	logic [CITY_W-1:0] fp_rd_q;
	logic [CITY_W-1:0] sp_rd_q;
	logic [VW-1:0]     ch_rd_q;

	logic [PW-1:0] pos_q;
	logic [PW-1:0] pos_d;
	logic [PW-1:0] ptr_q;
	logic [PW-1:0] ptr_d;
	logic [VW-1:0] fb_q;
	logic [VW-1:0] fb_d;
	logic [MW-1:0] mask_q;
	logic [MW-1:0] mask_d;
	logic [AW-1:0] ld_pos_q;
	logic [AW-1:0] ld_pos_d;
	logic [VW-1:0] lo_q;
	logic [VW-1:0] hi_q;
	logic [VW-1:0] swp_q;
	logic          swap_q;

	logic          run_start;
	logic          par_we;
	logic          ch_we;
	logic [VW-1:0] ch_wval;
	logic [VW-1:0] pos_v;
	logic [VW-1:0] cand;
	logic [VW-1:0] emit_k;
	logic [PW-1:0] ch_raddr;
	logic          in_seg;
	logic          scan_left;

	assign pos_v     = VW'(pos_q);
	assign cand      = VW'(sp_rd_q);
	assign in_seg    = (pos_v >= lo_q) && (pos_v <= hi_q);
	assign scan_left = (ptr_q < PW'(CITIES));

	always_comb begin
		if (swap_q && pos_v == swp_q) begin
			emit_k = swp_q + VW'(1);
		end else if (swap_q && pos_v == swp_q + VW'(1)) begin
			emit_k = swp_q;
		end else begin
			emit_k = pos_v;
		end
		ch_raddr = (emit_k == VW'(CITIES)) ? PW'(0) : PW'(emit_k);
	end

	always_ff @(posedge clk) begin
		if (par_we) begin
			fp_mem_q[ld_pos_q] <= cmd.gene_first;
			sp_mem_q[ld_pos_q] <= cmd.gene_second;
		end
		fp_rd_q <= fp_mem_q[pos_q[AW-1:0]];
		sp_rd_q <= sp_mem_q[ptr_q[AW-1:0]];
	end

	always_ff @(posedge clk) begin
		if (ch_we) begin
			ch_mem_q[pos_q] <= ch_wval;
		end
		ch_rd_q <= ch_mem_q[ch_raddr];
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid && cmd.func) begin
					state_d = B_COPY_RD;
				end
			end
			B_COPY_RD: begin
				state_d = B_COPY_WR;
			end
			B_COPY_WR: begin
				if (pos_v == hi_q) begin
					state_d = B_FILL;
				end else begin
					state_d = B_COPY_RD;
				end
			end
			B_FILL: begin
				if (pos_q == PW'(CITIES)) begin
					state_d = B_EMIT_RD;
				end else if (in_seg) begin
					state_d = B_FILL;
				end else if (scan_left) begin
					state_d = B_SCAN;
				end else begin
					state_d = B_FALL;
				end
			end
			B_SCAN: begin
				if (!mask_q[cand]) begin
					state_d = B_FILL;
				end else if (!scan_left) begin
					state_d = B_FALL;
				end
			end
			B_FALL: begin
				if (fb_q == VW'(CITIES) || !mask_q[fb_q]) begin
					state_d = B_FILL;
				end
			end
			B_EMIT_RD: begin
				state_d = B_EMIT_WR;
			end
			B_EMIT_WR: begin
				if (res_room) begin
					state_d = (pos_q == PW'(CITIES)) ? B_IDLE : B_EMIT_RD;
				end
			end
			default: begin
				state_d = B_IDLE;
			end
		endcase
	end

	always_comb begin
		cmd_pop   = 1'b0;
		run_start = 1'b0;
		par_we    = 1'b0;
		ch_we     = 1'b0;
		ch_wval   = '0;
		res_push  = 1'b0;
		res_data.child_gene = ch_rd_q[CITY_W-1:0];
		res_data.last       = (pos_q == PW'(CITIES));
		pos_d    = pos_q;
		ptr_d    = ptr_q;
		fb_d     = fb_q;
		mask_d   = mask_q;
		ld_pos_d = ld_pos_q;
		unique case (state_q)
			B_IDLE: begin
				if (cmd_valid) begin
					cmd_pop = 1'b1;
					if (cmd.func) begin
						run_start = 1'b1;
						pos_d     = PW'(VW'(cmd.lo));
						ptr_d     = '0;
						mask_d    = '0;
						ld_pos_d  = '0;
					end else begin
						par_we   = 1'b1;
						ld_pos_d = (ld_pos_q == AW'(CITIES - 1)) ? '0 : ld_pos_q + AW'(1);
					end
				end
			end
			B_COPY_RD: begin
			end
			B_COPY_WR: begin
				ch_we   = 1'b1;
				ch_wval = VW'(fp_rd_q);
				mask_d  = mask_q | (MW'(1) << VW'(fp_rd_q));
				pos_d   = (pos_v == hi_q) ? '0 : pos_q + PW'(1);
			end
			B_FILL: begin
				if (pos_q == PW'(CITIES)) begin
					pos_d = '0;
				end else if (in_seg) begin
					pos_d = pos_q + PW'(1);
				end else if (scan_left) begin
					ptr_d = ptr_q + PW'(1);
				end else begin
					fb_d = '0;
				end
			end
			B_SCAN: begin
				if (!mask_q[cand]) begin
					ch_we   = 1'b1;
					ch_wval = cand;
					mask_d  = mask_q | (MW'(1) << cand);
					pos_d   = pos_q + PW'(1);
				end else if (scan_left) begin
					ptr_d = ptr_q + PW'(1);
				end else begin
					fb_d = '0;
				end
			end
			B_FALL: begin
				if (fb_q == VW'(CITIES)) begin
					ch_we   = 1'b1;
					ch_wval = '0;
					mask_d  = mask_q | MW'(1);
					pos_d   = pos_q + PW'(1);
				end else if (!mask_q[fb_q]) begin
					ch_we   = 1'b1;
					ch_wval = fb_q;
					mask_d  = mask_q | (MW'(1) << fb_q);
					pos_d   = pos_q + PW'(1);
				end else begin
					fb_d = fb_q + VW'(1);
				end
			end
			B_EMIT_RD: begin
			end
			B_EMIT_WR: begin
				if (res_room) begin
					res_push = 1'b1;
					if (pos_q != PW'(CITIES)) begin
						pos_d = pos_q + PW'(1);
					end
				end
			end
			default: begin
			end
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= B_IDLE;
			pos_q    <= '0;
			ptr_q    <= '0;
			fb_q     <= '0;
			mask_q   <= '0;
			ld_pos_q <= '0;
			lo_q     <= '0;
			hi_q     <= '0;
			swp_q    <= '0;
			swap_q   <= 1'b0;
		end else begin
			state_q  <= state_d;
			pos_q    <= pos_d;
			ptr_q    <= ptr_d;
			fb_q     <= fb_d;
			mask_q   <= mask_d;
			ld_pos_q <= ld_pos_d;
			if (run_start) begin
				lo_q   <= VW'(cmd.lo);
				hi_q   <= VW'(cmd.hi);
				swp_q  <= VW'(cmd.swap_pos);
				swap_q <= cmd.swap_ok;
			end
		end
	end

	a_copy_in_seg: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == B_COPY_WR |-> (pos_v >= lo_q && pos_v <= hi_q))
		else $error("segment copy outside the cut positions");

	a_push_room: assert property (@(posedge clk) disable iff (!arst_n)
		res_push |-> res_room)
		else $error("result beat pushed without room");

	a_last_ends_run: assert property (@(posedge clk) disable iff (!arst_n)
		res_push && res_data.last |=> state_q == B_IDLE)
		else $error("sequencer still busy after closing beat");

endmodule

>>> design/ocx_out_q.sv
// Two-entry result queue between the sequencer and the result ports.
module ocx_out_q import ocx_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_push,
	input  res_t in_data,
	output logic room,
	output logic empty,
	input  logic pop,
	output res_t out_data
);

	res_t       ent_q [2];
	logic       wr_q;
	logic       rd_q;
	logic [1:0] cnt_q;
	logic       take;

	assign room     = (cnt_q != Q_FULL);
	assign empty    = (cnt_q == 2'd0);
	assign take     = pop && !empty;
	assign out_data = ent_q[rd_q];

	always_ff @(posedge clk) begin
		if (in_push) begin
			ent_q[wr_q] <= in_data;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q  <= 1'b0;
			rd_q  <= 1'b0;
			cnt_q <= 2'd0;
		end else begin
			if (in_push) begin
				wr_q <= ~wr_q;
			end
			if (take) begin
				rd_q <= ~rd_q;
			end
			if (in_push && !take) begin
				cnt_q <= cnt_q + 2'd1;
			end else if (!in_push && take) begin
				cnt_q <= cnt_q - 2'd1;
			end
		end
	end

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		in_push |-> cnt_q != Q_FULL)
		else $error("result queue overflow");

endmodule

>>> design/order_crossover_with_swap_mutation_core.sv
// Order crossover core top level: front end, sequencer and result queue.
// Load beats (func 0) store one city of each parent.
// A run beat (func 1) produces CITIES+1 result beats, the last flagged by last.
// The parent and child stores have one write port and one registered read
// port, so the segment copy and the result emission each pass through a read
// state and a write state per position, and filling passes through B_FILL per
// position plus B_SCAN per second-parent entry scanned, and B_FALL steps
// through the cities in order when the second parent runs out of unused cities.
// A two-entry command queue lets loads and runs arrive while a run is emitted.
module order_crossover_with_swap_mutation_core import ocx_pkg::*; #(
	parameter int CITIES = 8
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              push,
	output logic              full,
	input  logic              func,
	input  logic [CITY_W-1:0] gene_first,
	input  logic [CITY_W-1:0] gene_second,
	input  logic [CITY_W-1:0] cut_lo,
	input  logic [CITY_W-1:0] cut_hi,
	input  logic              swap_enable,
	input  logic [CITY_W-1:0] swap_pos,
	output logic              empty,
	input  logic              pop,
	output logic [CITY_W-1:0] child_gene,
	output logic              last
);

	logic cmd_valid;
	cmd_t cmd;
	logic cmd_pop;
	logic res_push;
	res_t res_in;
	logic res_room;
	res_t res_out;

	ocx_front #(
		.CITIES(CITIES)
	) u_front (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.full       (full),
		.func       (func),
		.gene_first (gene_first),
		.gene_second(gene_second),
		.cut_lo     (cut_lo),
		.cut_hi     (cut_hi),
		.swap_enable(swap_enable),
		.swap_pos   (swap_pos),
		.cmd_valid  (cmd_valid),
		.cmd        (cmd),
		.cmd_pop    (cmd_pop)
	);

	ocx_back #(
		.CITIES(CITIES)
	) u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd_valid(cmd_valid),
		.cmd      (cmd),
		.cmd_pop  (cmd_pop),
		.res_push (res_push),
		.res_data (res_in),
		.res_room (res_room)
	);

	ocx_out_q u_out_q (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_push (res_push),
		.in_data (res_in),
		.room    (res_room),
		.empty   (empty),
		.pop     (pop),
		.out_data(res_out)
	);

	assign child_gene = res_out.child_gene;
	assign last       = res_out.last;

endmodule
